>>> hw/rtl/midc_pkg.sv
// Shared constants, codes and types of the midpoint circle rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package midc_pkg;

	// Coordinate widths; everything else follows from the centre and radius width.
	localparam int COORD_WIDTH = 10;
	localparam int POS_WIDTH   = COORD_WIDTH + 1;
	localparam int DEC_WIDTH   = COORD_WIDTH + 4;
	localparam int PIX_WIDTH   = COORD_WIDTH + 2;

	// Step queue between the front and the back end.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

	// Request codes.
	typedef enum logic {
		REQ_START = 1'b0,
		REQ_STEP  = 1'b1
	} req_t;

	// Octants in plotting order, as offsets from the centre.
	typedef enum logic [2:0] {
		OCT_XY   = 3'd0,
		OCT_NXY  = 3'd1,
		OCT_NXNY = 3'd2,
		OCT_XNY  = 3'd3,
		OCT_NYX  = 3'd4,
		OCT_NYNX = 3'd5,
		OCT_YNX  = 3'd6,
		OCT_YX   = 3'd7
	} octant_t;

	// One step's worth of work for the back end.
	typedef struct packed {
		logic [COORD_WIDTH-1:0] center_x;
		logic [COORD_WIDTH-1:0] center_y;
		logic [POS_WIDTH-1:0]   pos_x;
		logic [POS_WIDTH-1:0]   pos_y;
		logic                   done;
	} job_t;

	// Queue status seen by both ends.
	typedef struct packed {
		logic full;
		logic not_empty;
	} q_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/midc_front.sv
// Front end: accepts items, keeps the circle state and queues one job per step while a circle runs.
`timescale 1ns / 1ps
`default_nettype none

module midc_front (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic                               req_type,
	input  wire logic [midc_pkg::COORD_WIDTH-1:0]   center_x,
	input  wire logic [midc_pkg::COORD_WIDTH-1:0]   center_y,
	input  wire logic [midc_pkg::COORD_WIDTH-1:0]   radius,
	input  wire midc_pkg::q_status_t                q_status,
	output logic                                    push,
	output midc_pkg::job_t                          push_job
);

	logic [midc_pkg::POS_WIDTH-1:0]          cur_x_q;
	logic [midc_pkg::POS_WIDTH-1:0]          cur_y_q;
	logic signed [midc_pkg::DEC_WIDTH-1:0]   decision_q;
	logic [midc_pkg::COORD_WIDTH-1:0]        held_cx_q;
	logic [midc_pkg::COORD_WIDTH-1:0]        held_cy_q;
	logic                                    running_q;

	logic                                    accept;
	logic                                    is_step;
	logic [midc_pkg::POS_WIDTH-1:0]          nx;
	logic signed [midc_pkg::POS_WIDTH:0]     ny_s;
	logic signed [midc_pkg::POS_WIDTH:0]     diff_s;
	logic signed [midc_pkg::DEC_WIDTH-1:0]   np;
	logic [midc_pkg::DEC_WIDTH-1:0]          start_dec;
	logic                                    done;

	// An item waits only while the queue has no room.
	assign in_stall = q_status.full;
	assign accept   = in_valid && !in_stall;
	assign is_step  = (req_type == midc_pkg::REQ_STEP);
	assign push     = accept && is_step && running_q;

	// Next position and decision value, using the updated x and y.
	always_comb begin
		nx     = cur_x_q + midc_pkg::POS_WIDTH'(1);
		ny_s   = $signed({1'b0, cur_y_q});
		diff_s = '0;
		if (decision_q <= 0) begin
			np = decision_q + $signed({{(midc_pkg::DEC_WIDTH - midc_pkg::POS_WIDTH - 1){1'b0}},
				nx, 1'b1});
		end else begin
			ny_s   = $signed({1'b0, cur_y_q}) - $signed((midc_pkg::POS_WIDTH + 1)'(1));
			diff_s = $signed({1'b0, nx}) - ny_s;
			np     = decision_q + $signed({{(midc_pkg::DEC_WIDTH - midc_pkg::POS_WIDTH - 2){
				diff_s[midc_pkg::POS_WIDTH]}}, diff_s, 1'b1});
		end
		done      = $signed({1'b0, nx}) > ny_s;
		start_dec = midc_pkg::DEC_WIDTH'(1)
			- {{(midc_pkg::DEC_WIDTH - midc_pkg::COORD_WIDTH){1'b0}}, radius};
	end

	// The job carries the point set of the current position.
	always_comb begin
		push_job.center_x = held_cx_q;
		push_job.center_y = held_cy_q;
		push_job.pos_x    = cur_x_q;
		push_job.pos_y    = cur_y_q;
		push_job.done     = done;
	end

	// Circle state: a start loads it, a step while running advances it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q    <= '0;
			cur_y_q    <= '0;
			decision_q <= '0;
			held_cx_q  <= '0;
			held_cy_q  <= '0;
			running_q  <= 1'b0;
		end else if (accept && !is_step) begin
			cur_x_q    <= '0;
			cur_y_q    <= {1'b0, radius};
			decision_q <= $signed(start_dec);
			held_cx_q  <= center_x;
			held_cy_q  <= center_y;
			running_q  <= 1'b1;
		end else if (push) begin
			cur_x_q    <= nx;
			cur_y_q    <= ny_s[midc_pkg::POS_WIDTH-1:0];
			decision_q <= np;
			if (done) begin
				running_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/midc_queue.sv
// Short job queue that decouples the front end from the point generator.
`timescale 1ns / 1ps
`default_nettype none

module midc_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire midc_pkg::job_t       push_job,
	input  wire logic                 pop,
	output midc_pkg::job_t            pop_job,
	output midc_pkg::q_status_t       q_status
);

	midc_pkg::job_t                   entry_q [midc_pkg::QUEUE_DEPTH];
	logic [midc_pkg::QPTR_WIDTH-1:0]  wr_ptr_q;
	logic [midc_pkg::QPTR_WIDTH-1:0]  rd_ptr_q;
	logic [midc_pkg::QCNT_WIDTH-1:0]  count_q;

	function automatic logic [midc_pkg::QPTR_WIDTH-1:0] next_ptr(
		input logic [midc_pkg::QPTR_WIDTH-1:0] ptr
	);
		if (ptr == midc_pkg::QPTR_WIDTH'(midc_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return ptr + midc_pkg::QPTR_WIDTH'(1);
	endfunction

	assign pop_job            = entry_q[rd_ptr_q];
	assign q_status.full      = (count_q == midc_pkg::QCNT_WIDTH'(midc_pkg::QUEUE_DEPTH));
	assign q_status.not_empty = (count_q != '0);

	// Entry storage; payload needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + midc_pkg::QCNT_WIDTH'(1);
				2'b01:   count_q <= count_q - midc_pkg::QCNT_WIDTH'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/midc_back.sv
// Back end: expands each queued job into its eight octant points, one per cycle while out_stall is low.
`timescale 1ns / 1ps
`default_nettype none

module midc_back (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire midc_pkg::q_status_t                  q_status,
	input  wire midc_pkg::job_t                       pop_job,
	output logic                                      pop,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [midc_pkg::PIX_WIDTH-1:0]     pixel_x,
	output logic signed [midc_pkg::PIX_WIDTH-1:0]     pixel_y,
	output logic [2:0]                                octant,
	output logic                                      last_of_step,
	output logic                                      circle_done
);

	midc_pkg::job_t                      job_q;
	logic                                job_valid_q;
	logic [2:0]                          cnt_q;
	logic                                out_valid_q;
	logic [midc_pkg::PIX_WIDTH-1:0]      pixel_x_q;
	logic [midc_pkg::PIX_WIDTH-1:0]      pixel_y_q;
	logic [2:0]                          octant_q;
	logic                                last_q;
	logic                                done_q;

	logic                                advance;
	logic                                emit;
	logic                                last;
	logic [midc_pkg::PIX_WIDTH-1:0]      cx;
	logic [midc_pkg::PIX_WIDTH-1:0]      cy;
	logic [midc_pkg::PIX_WIDTH-1:0]      ox;
	logic [midc_pkg::PIX_WIDTH-1:0]      oy;
	logic [midc_pkg::PIX_WIDTH-1:0]      px;
	logic [midc_pkg::PIX_WIDTH-1:0]      py;

	// The output register takes a new point whenever it is empty or being taken.
	assign advance = !out_valid_q || !out_stall;
	assign emit    = advance && job_valid_q;
	assign last    = (midc_pkg::octant_t'(cnt_q) == midc_pkg::OCT_YX);
	assign pop     = q_status.not_empty && (!job_valid_q || (emit && last));

	// Point of the current octant, wrapped to the pixel width.
	always_comb begin
		cx = {{(midc_pkg::PIX_WIDTH - midc_pkg::COORD_WIDTH){1'b0}}, job_q.center_x};
		cy = {{(midc_pkg::PIX_WIDTH - midc_pkg::COORD_WIDTH){1'b0}}, job_q.center_y};
		ox = {{(midc_pkg::PIX_WIDTH - midc_pkg::POS_WIDTH){1'b0}}, job_q.pos_x};
		oy = {{(midc_pkg::PIX_WIDTH - midc_pkg::POS_WIDTH){1'b0}}, job_q.pos_y};
		unique case (midc_pkg::octant_t'(cnt_q))
			midc_pkg::OCT_XY: begin
				px = cx + ox;
				py = cy + oy;
			end
			midc_pkg::OCT_NXY: begin
				px = cx - ox;
				py = cy + oy;
			end
			midc_pkg::OCT_NXNY: begin
				px = cx - ox;
				py = cy - oy;
			end
			midc_pkg::OCT_XNY: begin
				px = cx + ox;
				py = cy - oy;
			end
			midc_pkg::OCT_NYX: begin
				px = cx - oy;
				py = cy + ox;
			end
			midc_pkg::OCT_NYNX: begin
				px = cx - oy;
				py = cy - ox;
			end
			midc_pkg::OCT_YNX: begin
				px = cx + oy;
				py = cy - ox;
			end
			midc_pkg::OCT_YX: begin
				px = cx + oy;
				py = cy + ox;
			end
		endcase
	end

	// Job holding register and octant counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				job_valid_q <= 1'b1;
			end else if (emit && last) begin
				job_valid_q <= 1'b0;
			end
			if (emit) begin
				cnt_q <= cnt_q + 3'd1;
			end
			if (advance) begin
				out_valid_q <= job_valid_q;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= pop_job;
		end
		if (emit) begin
			pixel_x_q <= px;
			pixel_y_q <= py;
			octant_q  <= cnt_q;
			last_q    <= last;
			done_q    <= job_q.done;
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_x      = $signed(pixel_x_q);
	assign pixel_y      = $signed(pixel_y_q);
	assign octant       = octant_q;
	assign last_of_step = last_q;
	assign circle_done  = done_q;

endmodule

`default_nettype wire

>>> hw/rtl/midpoint_circle_rasterizer.sv
// Top level of the midpoint circle rasterizer.
//
//   Channel | Direction | Handshake          | Payload
//   in      | input     | in_valid/in_stall  | req_type, center_x, center_y, radius
//   out     | output    | out_valid/out_stall| pixel_x, pixel_y, octant, last_of_step,
//           |           |                    | circle_done
//
// A start item gives no point. A step item gives eight points, one per cycle while
// out_stall is low; the point generator in the back end sets the sustained step
// rate. The front end takes a step or start as long as the two-entry job queue has
// room, and stalls only when it is full. The first point of a step passes through
// the job queue, the back end's job register and the output register. Reset is asynchronous
// and leaves the block idle with empty queue and output.
`timescale 1ns / 1ps
`default_nettype none

module midpoint_circle_rasterizer (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic                                 req_type,
	input  wire logic [midc_pkg::COORD_WIDTH-1:0]     center_x,
	input  wire logic [midc_pkg::COORD_WIDTH-1:0]     center_y,
	input  wire logic [midc_pkg::COORD_WIDTH-1:0]     radius,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [midc_pkg::PIX_WIDTH-1:0]     pixel_x,
	output logic signed [midc_pkg::PIX_WIDTH-1:0]     pixel_y,
	output logic [2:0]                                octant,
	output logic                                      last_of_step,
	output logic                                      circle_done
);

	midc_pkg::q_status_t q_status;
	midc_pkg::job_t      push_job;
	midc_pkg::job_t      pop_job;
	logic                push;
	logic                pop;

	// Request handling and circle state.
	midc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.center_x (center_x),
		.center_y (center_y),
		.radius   (radius),
		.q_status (q_status),
		.push     (push),
		.push_job (push_job)
	);

	// Jobs in flight between the two ends.
	midc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.q_status (q_status)
	);

	// Point generation and output register.
	midc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_status     (q_status),
		.pop_job      (pop_job),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.octant       (octant),
		.last_of_step (last_of_step),
		.circle_done  (circle_done)
	);

endmodule

`default_nettype wire

>>> hw/rtl/midc_checker.sv
// Port-level checks of the midpoint circle rasterizer and their binding.
`timescale 1ns / 1ps
`default_nettype none

module midc_checker (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 out_valid,
	input wire logic                                 out_stall,
	input wire logic signed [midc_pkg::PIX_WIDTH-1:0] pixel_x,
	input wire logic signed [midc_pkg::PIX_WIDTH-1:0] pixel_y,
	input wire logic [2:0]                           octant,
	input wire logic                                 last_of_step,
	input wire logic                                 circle_done
);

	// The last point of a step is always the final octant.
	a_last_octant: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_of_step == (octant == 3'(midc_pkg::OCT_YX))))
		else $error("last_of_step does not match the final octant");

	// Within a step the points follow without a gap.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_of_step) |=> out_valid)
		else $error("gap inside the points of a step");

	// Within a step the octant advances by one per item.
	a_octant_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_of_step) |=> (octant == 3'($past(octant) + 3'd1)))
		else $error("octant order broken inside a step");

	// The end-of-circle flag is the same on every point of a step.
	a_done_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_of_step) |=> (circle_done == $past(circle_done)))
		else $error("circle_done changed inside a step");

	// A stalled result item holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(pixel_x) && $stable(pixel_y)
			&& $stable(octant)))
		else $error("stalled result item changed");

endmodule

bind midpoint_circle_rasterizer midc_checker u_midc_checker (.*);

`default_nettype wire

>>> sim/tb_midpoint_circle_rasterizer.sv
// Self-checking testbench for the midpoint circle rasterizer with a built-in point predictor.
`timescale 1ns / 1ps

module tb_midpoint_circle_rasterizer;

	localparam int QUIET_LIMIT = 1000;

	// One request waiting to be driven, with the idle cycles that go before it.
	typedef struct {
		midc_pkg::req_t                   req;
		logic [midc_pkg::COORD_WIDTH-1:0] cx;
		logic [midc_pkg::COORD_WIDTH-1:0] cy;
		logic [midc_pkg::COORD_WIDTH-1:0] r;
		int                               gap;
		bit                               drain;
	} circle_req_t;

	// One plotted point as the block should present it.
	typedef struct {
		logic signed [midc_pkg::PIX_WIDTH-1:0] px;
		logic signed [midc_pkg::PIX_WIDTH-1:0] py;
		midc_pkg::octant_t                     oct;
		logic                                  last;
		logic                                  done;
	} plot_point_t;

	logic                                   clk = 1'b0;
	logic                                   arst_n = 1'b0;
	logic                                   in_valid = 1'b0;
	logic                                   in_stall;
	midc_pkg::req_t                         req_type = midc_pkg::REQ_START;
	logic [midc_pkg::COORD_WIDTH-1:0]       center_x = '0;
	logic [midc_pkg::COORD_WIDTH-1:0]       center_y = '0;
	logic [midc_pkg::COORD_WIDTH-1:0]       radius = '0;
	logic                                   out_valid;
	logic                                   out_stall = 1'b0;
	logic signed [midc_pkg::PIX_WIDTH-1:0]  pixel_x;
	logic signed [midc_pkg::PIX_WIDTH-1:0]  pixel_y;
	logic [2:0]                             octant;
	logic                                   last_of_step;
	logic                                   circle_done;

	circle_req_t  req_queue[$];
	plot_point_t  points_due[$];
	circle_req_t  nxt_req;
	bit           burst = 1'b0;
	int           gap_left = 0;
	int           stall_left = 0;
	int           quiet_cycles = 0;
	int           fail_count = 0;
	int           starts_taken = 0;
	int           steps_plotted = 0;
	int           steps_idle = 0;
	int           points_checked = 0;

	// Predictor copy of the circle state.
	logic [midc_pkg::POS_WIDTH-1:0]         circ_x = '0;
	logic [midc_pkg::POS_WIDTH-1:0]         circ_y = '0;
	logic signed [midc_pkg::DEC_WIDTH-1:0]  circ_p = '0;
	logic [midc_pkg::COORD_WIDTH-1:0]       ctr_x = '0;
	logic [midc_pkg::COORD_WIDTH-1:0]       ctr_y = '0;
	bit                                     circ_live = 1'b0;

	midpoint_circle_rasterizer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.center_x     (center_x),
		.center_y     (center_y),
		.radius       (radius),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.octant       (octant),
		.last_of_step (last_of_step),
		.circle_done  (circle_done)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Number of steps that trace a whole circle of the given radius.
	function automatic int steps_of(int r);
		int x;
		int y;
		int p;
		int n;
		x = 0;
		y = r;
		p = 1 - r;
		n = 0;
		do begin
			n++;
			x++;
			if (p <= 0) begin
				p += 2 * x + 1;
			end else begin
				y--;
				p += 2 * (x - y) + 1;
			end
		end while (x <= y);
		return n;
	endfunction

	// Work out the points that one accepted item causes and queue them.
	task automatic plot_circle_item(midc_pkg::req_t rq, logic [midc_pkg::COORD_WIDTH-1:0] cx,
			logic [midc_pkg::COORD_WIDTH-1:0] cy, logic [midc_pkg::COORD_WIDTH-1:0] r);
		int x;
		int y;
		int p;
		int nx;
		int ny;
		int np;
		int dx;
		int dy;
		bit fin;
		plot_point_t pt;
		if (rq == midc_pkg::REQ_START) begin
			ctr_x = cx;
			ctr_y = cy;
			circ_x = '0;
			circ_y = {1'b0, r};
			circ_p = midc_pkg::DEC_WIDTH'(1 - int'(r));
			circ_live = 1'b1;
			starts_taken++;
			return;
		end
		if (!circ_live) begin
			steps_idle++;
			return;
		end
		x = circ_x;
		y = circ_y;
		p = circ_p;
		nx = x + 1;
		ny = y;
		if (p <= 0) begin
			np = p + 2 * nx + 1;
		end else begin
			ny = y - 1;
			np = p + 2 * (nx - ny) + 1;
		end
		fin = nx > ny;
		circ_x = midc_pkg::POS_WIDTH'(nx);
		circ_y = midc_pkg::POS_WIDTH'(ny);
		circ_p = midc_pkg::DEC_WIDTH'(np);
		if (fin)
			circ_live = 1'b0;
		steps_plotted++;
		// Eight symmetric points in plotting order.
		for (int k = 0; k < 8; k++) begin
			pt.oct = midc_pkg::octant_t'(k[2:0]);
			case (pt.oct)
				midc_pkg::OCT_XY:   begin dx = x;  dy = y;  end
				midc_pkg::OCT_NXY:  begin dx = -x; dy = y;  end
				midc_pkg::OCT_NXNY: begin dx = -x; dy = -y; end
				midc_pkg::OCT_XNY:  begin dx = x;  dy = -y; end
				midc_pkg::OCT_NYX:  begin dx = -y; dy = x;  end
				midc_pkg::OCT_NYNX: begin dx = -y; dy = -x; end
				midc_pkg::OCT_YNX:  begin dx = y;  dy = -x; end
				default:            begin dx = y;  dy = x;  end
			endcase
			pt.px = midc_pkg::PIX_WIDTH'(int'(ctr_x) + dx);
			pt.py = midc_pkg::PIX_WIDTH'(int'(ctr_y) + dy);
			pt.last = (k == 7);
			pt.done = fin;
			points_due.push_back(pt);
		end
	endtask

	task automatic add_item(midc_pkg::req_t rq, logic [midc_pkg::COORD_WIDTH-1:0] cx,
			logic [midc_pkg::COORD_WIDTH-1:0] cy, logic [midc_pkg::COORD_WIDTH-1:0] r,
			bit drain);
		circle_req_t it;
		it.req = rq;
		it.cx = cx;
		it.cy = cy;
		it.r = r;
		it.gap = burst ? 0 : $urandom_range(0, 3);
		it.drain = drain;
		req_queue.push_back(it);
	endtask

	// A step carries random payload, which the block must ignore.
	task automatic add_step();
		add_item(midc_pkg::REQ_STEP, midc_pkg::COORD_WIDTH'($urandom),
			midc_pkg::COORD_WIDTH'($urandom), midc_pkg::COORD_WIDTH'($urandom), 1'b0);
	endtask

	function automatic void check_field(string name, logic signed [31:0] want,
			logic signed [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Driver: presents queued items, predicts on acceptance, and idles between items.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_type <= midc_pkg::REQ_START;
			center_x <= '0;
			center_y <= '0;
			radius <= '0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall)
				plot_circle_item(req_type, center_x, center_y, radius);
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (req_queue.size() != 0 &&
						!(req_queue[0].drain && points_due.size() != 0)) begin
					nxt_req = req_queue.pop_front();
					req_type <= nxt_req.req;
					center_x <= nxt_req.cx;
					center_y <= nxt_req.cy;
					radius <= nxt_req.r;
					in_valid <= 1'b1;
					if (req_queue.size() != 0)
						gap_left = req_queue[0].gap;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares each accepted point with the oldest prediction and stalls at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (points_due.size() == 0) begin
					$error("point (%0d, %0d) octant %0d arrived with none expected",
						pixel_x, pixel_y, octant);
					fail_count++;
				end else begin
					check_field("pixel_x", points_due[0].px, pixel_x);
					check_field("pixel_y", points_due[0].py, pixel_y);
					check_field("octant", points_due[0].oct, octant);
					check_field("last_of_step", points_due[0].last, last_of_step);
					check_field("circle_done", points_due[0].done, circle_done);
					void'(points_due.pop_front());
				end
				points_checked++;
				// Every third stretch of points goes through with no stalling.
				stall_left = ((points_checked / 48) % 3 == 1) ? 0 : $urandom_range(0, 3);
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog on cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timed out after %0d cycles with no traffic.", quiet_cycles);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int counted;
		int r;
		int full;
		int n;

		// Directed part: idle steps, zero radius, the coordinate extremes, and restarts.
		add_item(midc_pkg::REQ_STEP, 10'h3FF, 10'h3FF, 10'h3FF, 1'b0);
		add_item(midc_pkg::REQ_START, 10'd0, 10'd0, 10'd0, 1'b0);
		add_step();
		add_step();
		add_item(midc_pkg::REQ_START, 10'h3FF, 10'h3FF, 10'd1, 1'b0);
		repeat (steps_of(1)) add_step();
		add_step();
		add_item(midc_pkg::REQ_START, 10'd0, 10'h3FF, 10'h3FF, 1'b1);
		repeat (3) add_step();
		add_item(midc_pkg::REQ_START, 10'h3FF, 10'd0, 10'h3FF, 1'b0);
		repeat (3) add_step();
		add_item(midc_pkg::REQ_START, 10'h155, 10'h2AA, 10'h155, 1'b0);
		add_step();
		add_item(midc_pkg::REQ_START, 10'h2AA, 10'h155, 10'd3, 1'b1);
		repeat (steps_of(3)) add_step();

		// Random circles: mostly small and traced to the end, some cut short by a new start.
		counted = 0;
		while (counted < 120) begin
			if ($urandom_range(0, 2) == 0)
				burst = !burst;
			r = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 12);
			full = steps_of(r);
			if (r > 40 || $urandom_range(0, 4) == 0)
				n = $urandom_range(0, (full > 6) ? 6 : full - 1);
			else
				n = full;
			add_item(midc_pkg::REQ_START, midc_pkg::COORD_WIDTH'($urandom),
				midc_pkg::COORD_WIDTH'($urandom), midc_pkg::COORD_WIDTH'(r),
				$urandom_range(0, 5) == 0);
			repeat (n) add_step();
			counted += 1 + n;
			// Occasionally keep stepping a circle that has already ended.
			if (n == full && $urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 2)) add_step();
		end

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (req_queue.size() != 0 || in_valid)
			@(posedge clk);
		while (points_due.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (points_due.size() != 0) begin
			$error("%0d expected points never arrived", points_due.size());
			fail_count++;
		end
		$display("Covered %0d circle starts, %0d plotting steps and %0d steps on an idle block,",
			starts_taken, steps_plotted, steps_idle);
		$display("with %0d points compared against the prediction.", points_checked);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
